FILE: design/k_smallest_max_heap_selector_defines.svh
// assertion macros for the k smallest selector checker
// no dependencies; included by the checker file only
`ifndef K_SMALLEST_MAX_HEAP_SELECTOR_DEFINES_SVH
`define K_SMALLEST_MAX_HEAP_SELECTOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define KSEL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ksel implication check failed");

// next-cycle implication, disabled while reset is low
`define KSEL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ksel next-cycle check failed");

`endif

FILE: design/ksel_pkg.sv
// shared types and constants of the k smallest selector
// no dependencies; used by the top level and the checker
`default_nettype none

package ksel_pkg;

  localparam int KEY_W          = 32;
  localparam int IDX_W          = 32;
  localparam int TDATA_W        = KEY_W + IDX_W;
  localparam int CFG_W          = 5;
  localparam int DEF_HEAP_DEPTH = 16;

  localparam logic [CFG_W-1:0] K_RESET = CFG_W'(16);

  // one stored heap entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

FILE: design/ksel_ram.sv
// generic single-write, single-read ram with a registered read port
// no dependencies
`default_nettype none

module ksel_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: design/k_smallest_max_heap_selector.sv
// top level of the k smallest selector: max-heap in two mirrored rams
// depends on ksel_pkg and ksel_ram
//
//  channel | ports                          | contents (lowest bit up)
//  --------+--------------------------------+-------------------------------------
//  in      | in_tvalid/in_tready/in_tdata   | sample_key, sample_index; tlast=last
//  out     | out_tvalid/out_tready/out_tdata| kept_key, kept_index; tlast=last entry
//  cfg     | cfg_valid/cfg_ready/cfg_data   | k_count, always ready
//
// insert, not full: read and compare per parent, then a root write if it gets there
// full heap: a root check, then one child pair read per level sunk, plus one
// readout: a ram read and an output load per stored entry, longer when out stalls
// reset clears control state only; heap contents are not cleared, nothing is swept
// one sample at a time: in_tready is high only while the sequencer is idle
`default_nettype none

module k_smallest_max_heap_selector #(
  parameter int HEAP_DEPTH = ksel_pkg::DEF_HEAP_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // in_tdata: [31:0] sample_key, [63:32] sample_index
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [ksel_pkg::TDATA_W-1:0] in_tdata,
  input  wire logic                         in_tlast,
  // out_tdata: [31:0] kept_key, [63:32] kept_index
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic      [ksel_pkg::TDATA_W-1:0] out_tdata,
  output logic                              out_tlast,
  // cfg_data: [4:0] k_count
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [ksel_pkg::CFG_W-1:0]   cfg_data
);

  import ksel_pkg::*;

  localparam int PW = $clog2(HEAP_DEPTH);       // heap position width
  localparam int FW = $clog2(HEAP_DEPTH + 1);   // fill count width
  localparam int CW = ((FW > CFG_W) ? FW : CFG_W) + 1;  // child / compare width

  localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_ROOT_RD  = 9'b000000010,
    S_ROOT_CMP = 9'b000000100,
    S_UP       = 9'b000001000,
    S_UP_CMP   = 9'b000010000,
    S_DN_RD    = 9'b000100000,
    S_DN_CMP   = 9'b001000000,
    S_OUT_RD   = 9'b010000000,
    S_OUT_WR   = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;      // hole position, or readout position
  entry_t           cur_r, cur_nxt;      // the sample being placed
  logic             last_r, last_nxt;
  logic [CFG_W-1:0] k_r;
  entry_t           out_r, out_nxt;
  logic             out_tlast_r, out_tlast_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;

  // ram ports: both copies take every write, each has its own read address
  logic             we;
  logic [PW-1:0]    waddr;
  entry_t           wdata;
  logic [PW-1:0]    raddr_a, raddr_b;
  logic [ENTRY_W-1:0] rdata_a_raw, rdata_b_raw;
  entry_t           rd_a, rd_b;

  logic [CW-1:0]    fill_c, k_c, keff_c, pos_c, l_c, r_c;
  logic             l_ok, r_ok;
  logic [PW-1:0]    parent_c;
  logic             sel_l, sel_r;
  logic [KEY_W-1:0] big_key;
  state_t           done_state;

  ksel_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a_raw)
  );

  ksel_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b_raw)
  );

  assign rd_a = entry_t'(rdata_a_raw);
  assign rd_b = entry_t'(rdata_b_raw);

  // effective k: zero acts as one, anything past the depth acts as the depth
  assign fill_c = CW'(fill_r);
  assign k_c    = CW'(k_r);
  always_comb begin
    if (k_c == '0) begin
      keff_c = CW'(1);
    end else if (k_c > DEPTH_C) begin
      keff_c = DEPTH_C;
    end else begin
      keff_c = k_c;
    end
  end

  // heap neighbors of the current position
  assign pos_c    = CW'(pos_r);
  assign l_c      = (pos_c << 1) + CW'(1);
  assign r_c      = (pos_c << 1) + CW'(2);
  assign l_ok     = (l_c < fill_c);
  assign r_ok     = (r_c < fill_c);
  assign parent_c = (pos_r - PW'(1)) >> 1;

  // sift-down pick: left first, right only if strictly greater than the winner
  assign sel_l   = l_ok && (rd_a.key > cur_r.key);
  assign big_key = sel_l ? rd_a.key : cur_r.key;
  assign sel_r   = r_ok && (rd_b.key > big_key);

  // where to go once the sample sits in its place
  assign done_state = last_r ? S_OUT_RD : S_IDLE;

  // read addresses
  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    unique case (state_r)
      S_UP: begin
        raddr_a = parent_c;
      end
      S_DN_RD: begin
        raddr_a = l_ok ? l_c[PW-1:0] : '0;
        raddr_b = r_ok ? r_c[PW-1:0] : '0;
      end
      S_OUT_RD, S_OUT_WR: begin
        raddr_a = pos_r;
      end
      S_IDLE, S_ROOT_RD, S_ROOT_CMP, S_UP_CMP, S_DN_CMP: begin
        raddr_a = '0;   // root for the replace check, otherwise unused
      end
      default: begin
        raddr_a = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    pos_nxt        = pos_r;
    cur_nxt        = cur_r;
    last_nxt       = last_r;
    out_nxt        = out_r;
    out_tlast_nxt  = out_tlast_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    we             = 1'b0;
    waddr          = pos_r;
    wdata          = cur_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cur_nxt.key = in_tdata[KEY_W-1:0];
          cur_nxt.idx = in_tdata[TDATA_W-1:KEY_W];
          last_nxt    = in_tlast;
          if (fill_c < keff_c) begin
            // append at the end of the heap and climb
            pos_nxt   = fill_r[PW-1:0];
            fill_nxt  = fill_r + FW'(1);
            state_nxt = S_UP;
          end else begin
            state_nxt = S_ROOT_RD;
          end
        end
      end
      S_ROOT_RD: begin
        state_nxt = S_ROOT_CMP;
      end
      S_ROOT_CMP: begin
        // replace only on a strictly greater root
        if (rd_a.key > cur_r.key) begin
          pos_nxt   = '0;
          state_nxt = S_DN_RD;
        end else begin
          pos_nxt   = '0;
          state_nxt = done_state;
        end
      end
      S_UP: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          state_nxt = done_state;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (cur_r.key > rd_a.key) begin
          // parent moves down into the hole
          wdata     = rd_a;
          pos_nxt   = parent_c;
          state_nxt = S_UP;
        end else begin
          pos_nxt   = '0;
          state_nxt = done_state;
        end
      end
      S_DN_RD: begin
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (sel_r) begin
          wdata     = rd_b;
          pos_nxt   = r_c[PW-1:0];
          state_nxt = S_DN_RD;
        end else if (sel_l) begin
          wdata     = rd_a;
          pos_nxt   = l_c[PW-1:0];
          state_nxt = S_DN_RD;
        end else begin
          pos_nxt   = '0;
          state_nxt = done_state;
        end
      end
      S_OUT_RD: begin
        state_nxt = S_OUT_WR;
      end
      S_OUT_WR: begin
        if (!out_tvalid_r || out_tready) begin
          out_nxt        = rd_a;
          out_tvalid_nxt = 1'b1;
          out_tlast_nxt  = (pos_c + CW'(1) == fill_c);
          if (pos_c + CW'(1) == fill_c) begin
            fill_nxt  = '0;
            pos_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = pos_r + PW'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      pos_r        <= '0;
      last_r       <= 1'b0;
      k_r          <= K_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      pos_r        <= pos_nxt;
      last_r       <= last_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid) begin
        k_r <= cfg_data;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    out_r       <= out_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_r.idx, out_r.key};
  assign out_tlast  = out_tlast_r;

endmodule

`default_nettype wire

FILE: design/ksel_checker.sv
// port-level checker for the k smallest selector, bound to the top level
// depends on ksel_pkg and k_smallest_max_heap_selector_defines.svh
`default_nettype none

`include "k_smallest_max_heap_selector_defines.svh"

module ksel_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_tvalid,
  input wire logic                         in_tready,
  input wire logic [ksel_pkg::TDATA_W-1:0] in_tdata,
  input wire logic                         in_tlast,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [ksel_pkg::TDATA_W-1:0] out_tdata,
  input wire logic                         out_tlast,
  input wire logic                         cfg_valid,
  input wire logic                         cfg_ready,
  input wire logic [ksel_pkg::CFG_W-1:0]   cfg_data
);

  import ksel_pkg::*;

  // config is never back-pressured
  `KSEL_ASSERT_IMPL(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

  // every accepted sample leaves the sequencer busy in the next cycle
  `KSEL_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // a readout run that is not finished keeps new samples out
  `KSEL_ASSERT_IMPL(a_run_blocks_in, clk, rst_n, out_tvalid && !out_tlast, !in_tready)

  // a stalled result holds
  `KSEL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind k_smallest_max_heap_selector ksel_checker u_ksel_checker (.*);

`default_nettype wire

FILE: sim/k_smallest_max_heap_selector_tb.sv
// self-checking testbench for k_smallest_max_heap_selector: directed table, then random sets
// depends on ksel_pkg and the selector rtl; predicts readout entries with its own heap copy, except typed rows
`default_nettype none

module k_smallest_max_heap_selector_tb;
  import ksel_pkg::*;

  localparam int DEPTH        = DEF_HEAP_DEPTH;
  localparam int TARGET_ITEMS = 260;
  localparam int DRAIN_CYCLES = 40;      // covers a full sift and the readout tail
  localparam int CYCLE_LIMIT  = 400000;  // bound on the whole run; the slowest legal run stays well under it
  localparam int RX_HOLD_LEN  = 400;     // long receiver hold-off, fills the block
  localparam int MAX_SHOWN    = 200;

  // one readout entry as seen on the out channel
  typedef struct {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
    logic             last;
  } kept_t;

  typedef enum logic {ROW_SAMPLE, ROW_SET_K} row_kind_t;

  // directed row; typed rows carry their single readout entry written in by hand
  typedef struct {
    row_kind_t        kind;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic [CFG_W-1:0] kval;
    bit               typed;
    logic [KEY_W-1:0] tkey;
    logic [IDX_W-1:0] tidx;
  } row_t;

  localparam int NUM_ROWS = 24;

  row_t dir_rows [NUM_ROWS] = '{
    // all-ones sample alone right after reset
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 5'd0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    // all-zero sample alone
    '{ROW_SAMPLE, 32'h0000_0000, 32'h0000_0000, 1'b1, 5'd0, 1'b1, 32'h0000_0000, 32'h0000_0000},
    // zero k acts as one
    '{ROW_SET_K,  32'h0, 32'h0, 1'b0, 5'd0, 1'b0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 32'd5, 32'd1, 1'b0, 5'd0, 1'b0, 32'h0, 32'h0},
    // equal key must not replace the root
    '{ROW_SAMPLE, 32'd5, 32'd2, 1'b0, 5'd0, 1'b0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 32'd3, 32'd3, 1'b1, 5'd0, 1'b1, 32'd3, 32'd3},
    // k above the heap depth is clamped
    '{ROW_SET_K,  32'h0, 32'h0, 1'b0, 5'd31, 1'b0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 32'd10, 32'd20, 1'b0, 5'd0, 1'b0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 32'd20, 32'd21, 1'b0, 5'd0, 1'b0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 32'd30, 32'd22, 1'b0, 5'd0, 1'b0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 32'd40, 32'd23, 1'b1, 5'd0, 1'b0, 32'h0, 32'h0},
    '{ROW_SET_K,  32'h0, 32'h0, 1'b0, 5'd16, 1'b0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 32'h8000_0000, 32'hA5A5_A5A5, 1'b0, 5'd0, 1'b0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 32'h5A5A_5A5A, 1'b0, 5'd0, 1'b0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 32'h0000_0001, 32'h0000_0000, 1'b0, 5'd0, 1'b0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, 5'd0, 1'b0, 32'h0, 32'h0},
    // k lowered below the fill mid-set: heap counts as full, nothing dropped
    '{ROW_SET_K,  32'h0, 32'h0, 1'b0, 5'd2, 1'b0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 32'd2, 32'd30, 1'b0, 5'd0, 1'b0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 32'h8000_0000, 32'd31, 1'b0, 5'd0, 1'b0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 32'd0, 32'd32, 1'b1, 5'd0, 1'b0, 32'h0, 32'h0},
    '{ROW_SET_K,  32'h0, 32'h0, 1'b0, 5'd1, 1'b0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 32'd9, 32'd40, 1'b0, 5'd0, 1'b0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 32'd9, 32'd41, 1'b1, 5'd0, 1'b1, 32'd9, 32'd40},
    '{ROW_SET_K,  32'h0, 32'h0, 1'b0, 5'd16, 1'b0, 32'h0, 32'h0}
  };

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [TDATA_W-1:0]  in_tdata;   // [31:0] sample_key, [63:32] sample_index
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [TDATA_W-1:0]  out_tdata;  // [31:0] kept_key, [63:32] kept_index
  logic                out_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data;   // [4:0] k_count

  // predictor state: heap copy, fill and the k register as the block sees it
  logic [KEY_W-1:0] heap_key [DEPTH];
  logic [IDX_W-1:0] heap_idx [DEPTH];
  int unsigned      heap_fill;
  logic [CFG_W-1:0] k_reg;

  kept_t       readout_q [$];   // entries still owed by the block, oldest first
  int unsigned err_count;
  int unsigned entries_seen;
  int unsigned samples_sent;
  int unsigned sets_done;
  int unsigned k_writes;
  int unsigned cycle_cnt;

  k_smallest_max_heap_selector #(.HEAP_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void exchange_slots(int unsigned a, int unsigned b);
    logic [KEY_W-1:0] tk;
    logic [IDX_W-1:0] ti;
    tk = heap_key[a];
    ti = heap_idx[a];
    heap_key[a] = heap_key[b];
    heap_idx[a] = heap_idx[b];
    heap_key[b] = tk;
    heap_idx[b] = ti;
  endfunction

  // applies one sample to the heap copy; on a last sample returns the readout run
  function automatic void predict_sample(input logic [KEY_W-1:0] key, input logic [IDX_W-1:0] idx,
                                         input logic last, output kept_t run [$]);
    int unsigned lim;
    int unsigned pos;
    int unsigned up;
    int unsigned big;
    int unsigned lc;
    int unsigned rc;
    run = {};
    lim = (k_reg == 0) ? 1 : ((k_reg > DEPTH) ? DEPTH : k_reg);
    if (heap_fill < lim) begin
      // append and climb while strictly greater than the parent
      heap_key[heap_fill] = key;
      heap_idx[heap_fill] = idx;
      pos = heap_fill;
      heap_fill++;
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (heap_key[pos] > heap_key[up]) begin
          exchange_slots(pos, up);
          pos = up;
        end else begin
          break;
        end
      end
    end else if (heap_fill > 0 && heap_key[0] > key) begin
      // replace the root and sink it; left child tested first, right wins only if greater
      heap_key[0] = key;
      heap_idx[0] = idx;
      pos = 0;
      forever begin
        big = pos;
        lc  = 2 * pos + 1;
        rc  = 2 * pos + 2;
        if (lc < heap_fill && heap_key[lc] > heap_key[big]) big = lc;
        if (rc < heap_fill && heap_key[rc] > heap_key[big]) big = rc;
        if (big == pos) break;
        exchange_slots(pos, big);
        pos = big;
      end
    end
    if (last) begin
      for (int unsigned i = 0; i < heap_fill; i++) begin
        run.push_back('{heap_key[i], heap_idx[i], (i + 1 == heap_fill)});
      end
      heap_fill = 0;
    end
  endfunction

  // offers one sample, leaves tvalid high after the transfer so back-to-back needs no gap
  task automatic send_sample(input logic [KEY_W-1:0] key, input logic [IDX_W-1:0] idx,
                             input logic last, input bit no_gap, input bit typed,
                             input kept_t typed_entry);
    int unsigned gap;
    kept_t       run [$];
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {idx, key};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
    predict_sample(key, idx, last, run);
    if (last) sets_done++;
    if (typed) begin
      readout_q.push_back(typed_entry);
    end else begin
      foreach (run[i]) readout_q.push_back(run[i]);
    end
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // idle means: nothing owed, and long enough for a sift that yields no entry to finish
  task automatic wait_idle();
    drop_valid();
    while (readout_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_k(input logic [CFG_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    k_reg = value;
    k_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls, stretches with none, and one long hold-off
  initial begin : receiver
    int unsigned stall_left;
    int unsigned free_left;
    bit          hold_done;
    stall_left = 0;
    free_left  = 0;
    hold_done  = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && entries_seen >= 40) begin
        // block fills up and has to stall its input while the sender keeps offering
        hold_done = 1;
        out_tready <= 1'b0;
        repeat (RX_HOLD_LEN) @(negedge clk);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (free_left > 0) begin
          free_left--;
        end else if ($urandom_range(0, 19) == 0) begin
          free_left = $urandom_range(30, 80);
        end else if ($urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // compare every out transfer against the oldest owed entry
  always @(posedge clk) begin : check_readout
    kept_t want;
    if (rst_n && out_tvalid && out_tready) begin
      entries_seen++;
      if (readout_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("%0t: unexpected entry key=%h idx=%h last=%b", $time,
                   out_tdata[KEY_W-1:0], out_tdata[TDATA_W-1:KEY_W], out_tlast);
      end else begin
        want = readout_q.pop_front();
        if (want.key !== out_tdata[KEY_W-1:0] || want.idx !== out_tdata[TDATA_W-1:KEY_W] ||
            want.last !== out_tlast) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("%0t: mismatch expected key=%h idx=%h last=%b, got key=%h idx=%h last=%b",
                     $time, want.key, want.idx, want.last, out_tdata[KEY_W-1:0],
                     out_tdata[TDATA_W-1:KEY_W], out_tlast);
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d entries still owed", cycle_cnt, readout_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    int unsigned      set_len;
    int unsigned      key_mode;
    int unsigned      set_no;
    int unsigned      cut_at;
    bit               no_gap;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] desc_key;
    kept_t            none;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    heap_fill = 0;
    k_reg     = K_RESET;
    err_count = 0;
    entries_seen = 0;
    samples_sent = 0;
    sets_done    = 0;
    k_writes     = 0;
    none = '{'0, '0, 1'b0};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_SET_K) begin
        write_k(dir_rows[r].kval);
      end else begin
        send_sample(dir_rows[r].key, dir_rows[r].idx, dir_rows[r].last, 1'b0, dir_rows[r].typed,
                    '{dir_rows[r].tkey, dir_rows[r].tidx, 1'b1});
      end
    end

    // random sets: every set ends with a last sample
    set_no = 0;
    while (samples_sent < TARGET_ITEMS) begin
      if (set_no > 0 && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 7))
          0:       write_k(5'd0);
          1:       write_k(5'd1);
          2:       write_k(5'd16);
          3:       write_k(5'd31);
          4:       write_k(5'd17);
          default: write_k(CFG_W'($urandom_range(1, 16)));
        endcase
      end
      set_len  = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 30) : $urandom_range(1, 12);
      key_mode = $urandom_range(0, 3);
      no_gap   = ($urandom_range(0, 4) == 0);
      desc_key = $urandom;
      cut_at   = ($urandom_range(0, 7) == 0 && set_len > 3) ? set_len / 2 : set_len;
      for (int unsigned n = 0; n < set_len; n++) begin
        if (n == cut_at) write_k(CFG_W'($urandom_range(1, 4)));
        case (key_mode)
          0: key = $urandom;
          1: key = $urandom_range(0, 7);    // many equal keys
          2: begin
            case ($urandom_range(0, 5))
              0:       key = 32'h0000_0000;
              1:       key = 32'hFFFF_FFFF;
              2:       key = 32'hFFFF_FFFE;
              3:       key = 32'h8000_0000;
              4:       key = 32'h7FFF_FFFF;
              default: key = $urandom;
            endcase
          end
          default: begin
            // falling keys keep replacing the root once full
            desc_key = desc_key - $urandom_range(1, 1 << 20);
            key      = desc_key;
          end
        endcase
        send_sample(key, $urandom, (n + 1 == set_len), no_gap, 1'b0, none);
      end
      if (set_no == 6) begin
        // sender pauses until the block has delivered everything owed
        drop_valid();
        while (readout_q.size() != 0) @(posedge clk);
      end
      set_no++;
    end

    wait_idle();
    $display("covered %0d samples in %0d sets, %0d k_count writes, %0d entries read out",
             samples_sent, sets_done, k_writes, entries_seen);
    if (err_count == 0 && readout_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatching entries", err_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: k_smallest_max_heap_selector.f
+incdir+design
design/ksel_pkg.sv
design/ksel_ram.sv
design/k_smallest_max_heap_selector.sv
design/ksel_checker.sv
sim/k_smallest_max_heap_selector_tb.sv
